>>> rtl/polar_bin_height_change_detector_unit_assert.svh
// Assertion macros for the checker file.
`ifndef POLAR_BIN_HEIGHT_CHANGE_DETECTOR_UNIT_ASSERT_SVH
`define POLAR_BIN_HEIGHT_CHANGE_DETECTOR_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PBH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PBH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/pbhcd_pkg.sv
// ----------------------------------------------------------------------------
// pbhcd_pkg
// Shared types and constants of the polar bin height change detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pbhcd_pkg;
  localparam int RingMax   = 32;
  localparam int SectorMax = 64;
  localparam int NumBins   = RingMax * SectorMax;
  localparam int AddrBits  = $clog2(NumBins);
  localparam int SecBits   = $clog2(SectorMax);
  localparam int RingBits  = $clog2(RingMax);

  typedef enum logic [1:0] {
    ActClear    = 2'd0,
    ActMap      = 2'd1,
    ActScan     = 2'd2,
    ActClassify = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StFew  = 2'd0,
    StMap  = 2'd1,
    StCurr = 2'd2,
    StMerge = 2'd3
  } status_e;

  localparam logic [2:0] CfgMinH = 3'd0;
  localparam logic [2:0] CfgMaxH = 3'd1;
  localparam logic [2:0] CfgMaxR = 3'd2;
  localparam logic [2:0] CfgRingW = 3'd3;
  localparam logic [2:0] CfgRingC = 3'd4;
  localparam logic [2:0] CfgSecC = 3'd5;
  localparam logic [2:0] CfgRatio = 3'd6;
  localparam logic [2:0] CfgMinP = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the transaction
    logic sqrt_step; // one root step plus one CORDIC step
    logic div_step;  // one restoring division step
    logic rd;        // issue the bin read
    logic calc;      // compute the update from the read data
    logic wr;        // write the bin back
    logic clr_wr;    // write the reset entry at the clear address
    logic done;      // present the result
  } cmd_t;

  typedef struct packed {
    logic keep;     // point lies in the region
    logic clr_last; // clear pass is at the last bin
  } stat_t;

  function automatic logic [15:0] atan_lut(input logic [3:0] i);
    logic [15:0] v;
    unique case (i)
      4'd0: v = 16'd8192;  4'd1: v = 16'd4836;  4'd2: v = 16'd2555;
      4'd3: v = 16'd1297;  4'd4: v = 16'd651;   4'd5: v = 16'd326;
      4'd6: v = 16'd163;   4'd7: v = 16'd81;    4'd8: v = 16'd41;
      4'd9: v = 16'd20;    4'd10: v = 16'd10;   4'd11: v = 16'd5;
      4'd12: v = 16'd3;    4'd13: v = 16'd1;    4'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction
endpackage

>>> rtl/pbhcd_datapath.sv
// ----------------------------------------------------------------------------
// pbhcd_datapath
// Radius root, CORDIC angle, ring division, bin store and classify rule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pbhcd_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbhcd_pkg::cmd_t     cmd_i,
  output pbhcd_pkg::stat_t    stat_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [1:0]          action_i,
  input  logic [15:0]         x_pos_i,
  input  logic [15:0]         y_pos_i,
  input  logic [15:0]         z_pos_i,
  input  logic [4:0]          ring_sel_i,
  input  logic [5:0]          sector_sel_i,
  output logic                in_region_o,
  output logic [4:0]          ring_index_o,
  output logic [5:0]          sector_index_o,
  output logic [1:0]          bin_status_o,
  output logic [15:0]         map_span_o,
  output logic [15:0]         curr_span_o
);
  import pbhcd_pkg::*;

  // Configuration registers.
  logic signed [15:0] min_h_q, max_h_q;
  logic [15:0] max_r_q, min_p_q;
  logic [14:0] ring_w_q;
  logic [5:0]  ring_c_q;
  logic [6:0]  sec_c_q;
  logic [8:0]  ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_h_q <= -16'sd256; max_h_q <= 16'sd768; max_r_q <= 16'd20480;
      ring_w_q <= 15'd512; ring_c_q <= 6'd20; sec_c_q <= 7'd60;
      ratio_q <= 9'd51; min_p_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinH:  min_h_q  <= cfg_data_i;
        CfgMaxH:  max_h_q  <= cfg_data_i;
        CfgMaxR:  max_r_q  <= cfg_data_i;
        CfgRingW: ring_w_q <= cfg_data_i[14:0];
        CfgRingC: ring_c_q <= cfg_data_i[5:0];
        CfgSecC:  sec_c_q  <= cfg_data_i[6:0];
        CfgRatio: ratio_q  <= cfg_data_i[8:0];
        default:  min_p_q  <= cfg_data_i;
      endcase
    end
  end

  // Captured transaction.
  action_e act_q;
  logic signed [15:0] z_q;
  logic [4:0] rsel_q;
  logic [5:0] ssel_q;
  logic [15:0] root_q;
  logic [3:0]  step_q;
  logic signed [34:0] cx_q, cy_q;
  logic signed [17:0] acc_q;
  logic [15:0] base_q;
  logic keep_q;
  logic [15:0] quo_q;
  logic [15:0] rem_q;

  // The sum of the coordinate squares is registered at load; one multiplier per coordinate.
  logic signed [31:0] xx, yy;
  logic [31:0] mr2;
  logic [32:0] ssum;
  assign xx  = $signed(x_pos_i) * $signed(x_pos_i);
  assign yy  = $signed(y_pos_i) * $signed(y_pos_i);
  assign ssum = {1'b0, xx} + {1'b0, yy};
  assign mr2 = 32'(max_r_q) * 32'(max_r_q);

  // Quarter turn normalization.
  logic signed [16:0] nx, ny, tx, ty;
  logic [15:0] nbase;
  always_comb begin
    nx = {x_pos_i[15], x_pos_i};
    ny = {y_pos_i[15], y_pos_i};
    tx = '0;
    nbase = '0;
    for (int i = 0; i < 3; i++) begin
      if (!(nx > 0 && ny >= 0)) begin
        tx = nx; nx = ny; ny = -tx;
        nbase = nbase + 16'd16384;
      end
    end
    ty = ny;
  end

  // Root by the classic digit recurrence on a 32-bit radicand.
  logic [31:0] rad_q;
  logic [17:0] rrem_q;
  logic [19:0] rrem_sh;
  logic [19:0] rtest;
  assign rrem_sh = {rrem_q, rad_q[31:30]};
  assign rtest   = {2'b00, root_q, 2'b01};

  // CORDIC step.
  logic signed [34:0] dx, dy;
  assign dx = cy_q >>> step_q;
  assign dy = cx_q >>> step_q;

  logic [14:0] rw_eff;
  assign rw_eff = (ring_w_q == '0) ? 15'd1 : ring_w_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_e'(action_i);
      z_q    <= z_pos_i;
      rsel_q <= ring_sel_i;
      ssel_q <= sector_sel_i;
      rad_q  <= ssum[31:0];
      rrem_q <= '0;
      root_q <= '0;
      step_q <= '0;
      keep_q <= ($signed(z_pos_i) < max_h_q) && ($signed(z_pos_i) > min_h_q) &&
                (ssum <= {1'b0, mr2});
      cx_q   <= {{2{nx[16]}}, nx, 16'd0};
      cy_q   <= {{2{ty[16]}}, ty, 16'd0};
      acc_q  <= '0;
      base_q <= ((x_pos_i == '0) && (y_pos_i == '0)) ? 16'd0 : nbase;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[29:0], 2'b00};
      if (rrem_sh >= rtest) begin
        rrem_q <= 18'(rrem_sh - rtest);
        root_q <= {root_q[14:0], 1'b1};
      end else begin
        rrem_q <= rrem_sh[17:0];
        root_q <= {root_q[14:0], 1'b0};
      end
      if (cy_q > 0) begin
        cx_q <= cx_q + dx; cy_q <= cy_q - dy;
        acc_q <= acc_q + $signed({2'b00, atan_lut(step_q)});
      end else begin
        cx_q <= cx_q - dx; cy_q <= cy_q + dy;
        acc_q <= acc_q - $signed({2'b00, atan_lut(step_q)});
      end
      step_q <= step_q + 4'd1;
      if (step_q == 4'd15) begin
        quo_q <= '0;
        rem_q <= '0;
      end
    end else if (cmd_i.div_step) begin
      // Restoring division of root by the ring width, one bit a step.
      if ({rem_q[14:0], root_q[15]} >= {1'b0, rw_eff}) begin
        rem_q <= {rem_q[14:0], root_q[15]} - {1'b0, rw_eff};
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[14:0], root_q[15]};
        quo_q <= {quo_q[14:0], 1'b0};
      end
      root_q <= {root_q[14:0], 1'b0};
    end
  end

  // Ring and sector of the point.
  logic [6:0] rc_eff;
  logic [6:0] nc_eff;
  logic [15:0] angle;
  logic [13:0] acc_cl;
  logic [22:0] sec_prod;
  logic [RingBits-1:0] ring_pt;
  logic [SecBits-1:0]  sec_pt;
  always_comb begin
    rc_eff = (ring_c_q == '0) ? 7'd1 : ((ring_c_q > 6'(RingMax)) ? 7'(RingMax)
             : {1'b0, ring_c_q});
    nc_eff = (sec_c_q == '0) ? 7'd1 : ((sec_c_q > 7'(SectorMax)) ? 7'(SectorMax)
             : sec_c_q);
    if (acc_q < 0) acc_cl = '0;
    else if (acc_q > 18'sd16383) acc_cl = 14'h3fff;
    else acc_cl = acc_q[13:0];
    angle = base_q + {2'b00, acc_cl};
    sec_prod = angle * nc_eff;
    ring_pt = (quo_q > 16'(rc_eff - 7'd1)) ? RingBits'(rc_eff - 7'd1)
              : quo_q[RingBits-1:0];
    sec_pt = (sec_prod[22:16] > nc_eff - 7'd1) ? SecBits'(nc_eff - 7'd1)
             : sec_prod[SecBits+15:16];
  end

  // Bin store: one word holds map and scan count, top and bottom.
  typedef struct packed {
    logic [15:0] mc; logic signed [15:0] mt; logic signed [15:0] mb;
    logic [15:0] sc; logic signed [15:0] st; logic signed [15:0] sb;
  } bin_t;
  localparam bin_t BinReset = '{mc: '0, mt: 16'sh8000, mb: 16'sh7fff,
                                sc: '0, st: 16'sh8000, sb: 16'sh7fff};

  bin_t mem [NumBins];
  bin_t rd_q, wd;
  logic [AddrBits-1:0] addr, clr_q;
  assign addr = (act_q == ActClassify) ? {rsel_q, ssel_q} : {ring_pt, sec_pt};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[addr];
    if (cmd_i.clr_wr) mem[clr_q] <= BinReset;
    else if (cmd_i.wr) mem[addr] <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
  end

  bin_t upd_q;
  always_comb begin
    wd = rd_q;
    if (act_q == ActMap) begin
      if (rd_q.mc != 16'hffff) wd.mc = rd_q.mc + 16'd1;
      if (z_q >= rd_q.mt) wd.mt = z_q;
      if (z_q <= rd_q.mb) wd.mb = z_q;
    end else begin
      if (rd_q.sc != 16'hffff) wd.sc = rd_q.sc + 16'd1;
      if (z_q >= rd_q.st) wd.st = z_q;
      if (z_q <= rd_q.sb) wd.sb = z_q;
    end
  end

  // Spans and classify rule evaluated on the registered word.
  bin_t ev;
  logic [15:0] mspan, cspan, lo, hi;
  logic [24:0] lhs, rhs;
  logic [1:0]  status;
  always_comb begin
    ev = upd_q;
    mspan = (ev.mc == '0 || ev.mt < ev.mb) ? 16'd0 : 16'(ev.mt - ev.mb);
    cspan = (ev.sc == '0 || ev.st < ev.sb) ? 16'd0 : 16'(ev.st - ev.sb);
    lo = (mspan < cspan) ? mspan : cspan;
    hi = (mspan < cspan) ? cspan : mspan;
    lhs = {1'b0, lo, 8'd0};
    rhs = ratio_q * hi;
    if (ev.mc == '0 || ev.sc == '0 || ev.sc < min_p_q) status = StFew;
    else if (lhs < rhs) status = (mspan >= cspan) ? StMap : StCurr;
    else status = StMerge;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) upd_q <= (act_q == ActClassify) ? rd_q : wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      if (act_q == ActClassify) begin
        in_region_o <= 1'b0; ring_index_o <= rsel_q; sector_index_o <= ssel_q;
        bin_status_o <= status; map_span_o <= mspan; curr_span_o <= cspan;
      end else if (act_q != ActClear && keep_q) begin
        in_region_o <= 1'b1; ring_index_o <= ring_pt; sector_index_o <= sec_pt;
        bin_status_o <= StFew; map_span_o <= mspan; curr_span_o <= cspan;
      end else begin
        in_region_o <= 1'b0; ring_index_o <= '0; sector_index_o <= '0;
        bin_status_o <= StFew; map_span_o <= '0; curr_span_o <= '0;
      end
    end
  end

  assign stat_o.keep     = keep_q;
  assign stat_o.clr_last = (clr_q == AddrBits'(NumBins - 1));
endmodule

>>> rtl/pbhcd_ctrl.sv
// ----------------------------------------------------------------------------
// pbhcd_ctrl
// Sequencer of the detector: root and angle steps, division, bin access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pbhcd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       action_i,
  input  pbhcd_pkg::stat_t stat_i,
  output pbhcd_pkg::cmd_t  cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import pbhcd_pkg::*;

  typedef enum logic [8:0] {
    SInit  = 9'b000000001,
    SIdle  = 9'b000000010,
    SRoot  = 9'b000000100,
    SDiv   = 9'b000001000,
    SRead  = 9'b000010000,
    SCalc  = 9'b000100000,
    SWrite = 9'b001000000,
    SOut   = 9'b010000000,
    SClear = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  action_e act_q;
  logic done_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      SInit, SClear: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = (state_q == SInit) ? SIdle : SOut;
      end
      SIdle: if (start_i) begin
        cmd_o.load = 1'b1;
        cnt_d = '0;
        unique case (action_e'(action_i))
          ActClear:    state_d = SClear;
          ActClassify: state_d = SRead;
          default:     state_d = SRoot;
        endcase
      end
      SRoot: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          cnt_d = '0;
          state_d = stat_i.keep ? SDiv : SCalc;
        end
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd15) state_d = SRead;
      end
      SRead: begin
        cmd_o.rd = 1'b1;
        state_d = SCalc;
      end
      SCalc: begin
        cmd_o.calc = 1'b1;
        state_d = ((act_q == ActClassify) || !stat_i.keep) ? SOut : SWrite;
      end
      SWrite: begin
        cmd_o.wr = 1'b1;
        state_d = SOut;
      end
      SOut: begin
        cmd_o.done = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      cnt_q   <= '0;
      act_q   <= ActClear;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= cmd_o.done;
      if (cmd_o.load) act_q <= action_e'(action_i);
    end
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;
endmodule

>>> rtl/polar_bin_height_change_detector_unit.sv
// ----------------------------------------------------------------------------
// polar_bin_height_change_detector_unit
// Polar grid binning of map and scan points with a per-bin height test.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake
// command  | in        | start_i while busy_o is low
// result   | out       | done_o, one cycle, no back pressure
// config   | in        | cfg_we_i, cfg_idx_i, cfg_data_i, any cycle when idle
//
// A point's result follows 16 root/CORDIC steps and 16 ring division steps,
// then read, update, write and output. A point outside the region skips the
// division, read and write. Classify reads, evaluates and outputs the bin;
// clear is a sweep of the bin memory one entry a cycle, then output. After
// reset the same sweep runs with busy_o high.
// The receiver cannot stall.
`timescale 1ns / 1ps
module polar_bin_height_change_detector_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  action_i,
  input  logic [15:0] x_pos_i,
  input  logic [15:0] y_pos_i,
  input  logic [15:0] z_pos_i,
  input  logic [4:0]  ring_sel_i,
  input  logic [5:0]  sector_sel_i,
  output logic        in_region_o,
  output logic [4:0]  ring_index_o,
  output logic [5:0]  sector_index_o,
  output logic [1:0]  bin_status_o,
  output logic [15:0] map_span_o,
  output logic [15:0] curr_span_o
);
  import pbhcd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pbhcd_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .action_i,
    .stat_i(stat), .cmd_o(cmd), .busy_o, .done_o
  );

  pbhcd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .action_i, .x_pos_i, .y_pos_i, .z_pos_i, .ring_sel_i, .sector_sel_i,
    .in_region_o, .ring_index_o, .sector_index_o, .bin_status_o,
    .map_span_o, .curr_span_o
  );
endmodule

>>> rtl/pbhcd_checker.sv
// ----------------------------------------------------------------------------
// pbhcd_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polar_bin_height_change_detector_unit_assert.svh"
module pbhcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       in_region_o,
  input logic [1:0] bin_status_o
);
  import pbhcd_pkg::*;

  `PBH_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `PBH_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `PBH_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `PBH_ASSERT_IMP(a_point_status, clk_i, rst_ni, done_o && in_region_o, bin_status_o == StFew)
endmodule

bind polar_bin_height_change_detector_unit pbhcd_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .in_region_o, .bin_status_o
);
